@@ design/hbv_pkg.sv @@
// ----------------------------------------------------------------------------
// hbv_pkg: shared types and constants of the block variance engine
// Field widths, register indexes, bit-depth mode codes and the payload
// structs that travel between the front end, the queues and the back end.
// ----------------------------------------------------------------------------
package hbv_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int DIFF_W    = SAMPLE_W + 1;
    localparam int SQ_W      = 2 * SAMPLE_W;
    localparam int SSE_ACC_W = 37;
    localparam int SUM_W     = 25;
    localparam int SSE_OUT_W = 32;
    localparam int VAR_W     = 32;
    localparam int LOG2_W    = 3;
    localparam int SHIFT_W   = LOG2_W + 1;
    localparam int SSQ_W     = 2 * SUM_W - 1;

    localparam int MID_Q_DEPTH = 4;
    localparam int OUT_Q_DEPTH = 4;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    typedef enum logic [1:0] {
        REG_MODE     = 2'd0,
        REG_LOG2_WID = 2'd1,
        REG_LOG2_HGT = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_8BIT  = 2'd0,
        MODE_10BIT = 2'd1,
        MODE_12BIT = 2'd2
    } t_mode;

    typedef struct packed {
        t_mode             mode;
        logic [LOG2_W-1:0] log2_wid;
        logic [LOG2_W-1:0] log2_hgt;
    } t_cfg;

    typedef struct packed {
        logic signed [DIFF_W-1:0] diff;
        logic [SQ_W-1:0]          sq;
        logic                     last;
    } t_item;

    typedef struct packed {
        logic [SSE_OUT_W-1:0]    sse;
        logic signed [SUM_W-1:0] sum;
        logic [VAR_W-1:0]        var_val;
    } t_result;

endpackage

@@ design/hbv_fifo.sv @@
// ----------------------------------------------------------------------------
// hbv_fifo: small first-in first-out queue
// Register-based queue with registered storage and a combinational head.
// The producer must not push while full, the consumer must not pop while empty.
// ----------------------------------------------------------------------------
module hbv_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

@@ design/hbv_regs.sv @@
// ----------------------------------------------------------------------------
// hbv_regs: configuration registers behind the APB-style port
// Holds the bit-depth mode and the block size exponents, with read-back.
// ----------------------------------------------------------------------------
module hbv_regs
    import hbv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_mode             r_mode;
    logic [LOG2_W-1:0] r_log2_wid;
    logic [LOG2_W-1:0] r_log2_hgt;
    t_reg_idx          reg_idx;
    logic              wr_en;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_8BIT;
            r_log2_wid <= LOG2_W'(4);
            r_log2_hgt <= LOG2_W'(4);
        end else if (wr_en) begin
            case (reg_idx)
                REG_MODE:     r_mode     <= t_mode'(pwdata[1:0]);
                REG_LOG2_WID: r_log2_wid <= pwdata[LOG2_W-1:0];
                REG_LOG2_HGT: r_log2_hgt <= pwdata[LOG2_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MODE:     prdata = {{(APB_DW - 2){1'b0}}, r_mode};
            REG_LOG2_WID: prdata = {{(APB_DW - LOG2_W){1'b0}}, r_log2_wid};
            REG_LOG2_HGT: prdata = {{(APB_DW - LOG2_W){1'b0}}, r_log2_hgt};
            default:      prdata = '0;
        endcase
    end

    assign o_cfg.mode     = r_mode;
    assign o_cfg.log2_wid = r_log2_wid;
    assign o_cfg.log2_hgt = r_log2_hgt;

endmodule

@@ design/hbv_front.sv @@
// ----------------------------------------------------------------------------
// hbv_front: sample pair intake
// Accepts one source/reference pair per beat, forms the difference and its
// square, and hands the resulting item to the middle queue.
// ----------------------------------------------------------------------------
module hbv_front
    import hbv_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic [SAMPLE_W-1:0] i_src_sample,
    input  logic [SAMPLE_W-1:0] i_ref_sample,
    input  logic                i_last_sample,
    input  logic                i_q_full,
    output logic                o_q_push,
    output t_item               o_item
);

    logic                     r_vld;
    t_item                    r_item;
    logic                     load;
    logic signed [DIFF_W-1:0] diff;
    logic signed [SQ_W:0]     sq_full;

    // The staging register frees up whenever its item moves into the queue.
    assign o_q_push = r_vld && !i_q_full;
    assign o_full   = r_vld && i_q_full;
    assign load     = i_push && !o_full;

    assign diff    = $signed({1'b0, i_src_sample}) - $signed({1'b0, i_ref_sample});
    assign sq_full = diff * diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (load) begin
            r_vld <= 1'b1;
        end else if (o_q_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item.diff <= diff;
            r_item.sq   <= sq_full[SQ_W-1:0];
            r_item.last <= i_last_sample;
        end
    end

    assign o_item = r_item;

endmodule

@@ design/hbv_back.sv @@
// ----------------------------------------------------------------------------
// hbv_back: accumulation and block finish
// Pops items from the middle queue, accumulates sum and sse, and on the last
// pair runs rounding, squaring of the sum and the variance step.
// ----------------------------------------------------------------------------
module hbv_back
    import hbv_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_mid_empty,
    input  t_item   i_item,
    output logic    o_mid_pop,
    input  logic    i_out_full,
    output logic    o_out_push,
    output t_result o_result
);

    logic                    adv;

    logic [SSE_ACC_W-1:0]    r_sse_acc;
    logic signed [SUM_W-1:0] r_sum_acc;
    logic [SSE_ACC_W-1:0]    sse_next;
    logic signed [SUM_W-1:0] sum_next;

    logic                    r_t_vld;
    logic [SSE_ACC_W-1:0]    r_t_sse;
    logic signed [SUM_W-1:0] r_t_sum;

    logic                    r_r_vld;
    logic [SSE_OUT_W-1:0]    r_r_sse;
    logic signed [SUM_W-1:0] r_r_sum;

    logic                    r_m_vld;
    logic [SSE_OUT_W-1:0]    r_m_sse;
    logic signed [SUM_W-1:0] r_m_sum;
    logic [SSQ_W-1:0]        r_m_sq;

    logic signed [SUM_W:0]   sum_ext;
    logic signed [SUM_W:0]   sum_rnd10;
    logic signed [SUM_W:0]   sum_rnd12;
    logic signed [SUM_W:0]   sum_sh10;
    logic signed [SUM_W:0]   sum_sh12;
    logic [SSE_ACC_W:0]      sse_rnd10;
    logic [SSE_ACC_W:0]      sse_rnd12;
    logic [SSE_OUT_W-1:0]    sse_round;
    logic signed [SUM_W-1:0] sum_round;

    logic signed [2*SUM_W-1:0] prod;

    logic [SHIFT_W-1:0]      shift;
    logic [SSQ_W-1:0]        ssq;
    logic [VAR_W-1:0]        var_val;

    // The whole back end holds while a finished result cannot enter the
    // output queue.
    assign adv        = !(r_m_vld && i_out_full);
    assign o_mid_pop  = !i_mid_empty && adv;
    assign o_out_push = r_m_vld && !i_out_full;

    assign sse_next = r_sse_acc + {{(SSE_ACC_W - SQ_W){1'b0}}, i_item.sq};
    assign sum_next = r_sum_acc + {{(SUM_W - DIFF_W){i_item.diff[DIFF_W-1]}}, i_item.diff};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sse_acc <= '0;
            r_sum_acc <= '0;
            r_t_vld   <= 1'b0;
        end else if (adv) begin
            r_t_vld <= o_mid_pop && i_item.last;
            if (o_mid_pop) begin
                if (i_item.last) begin
                    r_sse_acc <= '0;
                    r_sum_acc <= '0;
                end else begin
                    r_sse_acc <= sse_next;
                    r_sum_acc <= sum_next;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && o_mid_pop && i_item.last) begin
            r_t_sse <= sse_next;
            r_t_sum <= sum_next;
        end
    end

    // Rounding adds half of the divisor; the sum is shifted arithmetically,
    // so a negative sum rounds towards minus infinity.
    assign sum_ext   = {r_t_sum[SUM_W-1], r_t_sum};
    assign sum_rnd10 = sum_ext + (SUM_W + 1)'(2);
    assign sum_rnd12 = sum_ext + (SUM_W + 1)'(8);
    assign sum_sh10  = sum_rnd10 >>> 2;
    assign sum_sh12  = sum_rnd12 >>> 4;
    assign sse_rnd10 = {1'b0, r_t_sse} + (SSE_ACC_W + 1)'(8);
    assign sse_rnd12 = {1'b0, r_t_sse} + (SSE_ACC_W + 1)'(128);

    always_comb begin
        case (i_cfg.mode)
            MODE_8BIT: begin
                sse_round = r_t_sse[SSE_OUT_W-1:0];
                sum_round = r_t_sum;
            end
            MODE_10BIT: begin
                sse_round = sse_rnd10[SSE_OUT_W+3:4];
                sum_round = sum_sh10[SUM_W-1:0];
            end
            default: begin
                sse_round = {2'b00, sse_rnd12[SSE_ACC_W:8]};
                sum_round = sum_sh12[SUM_W-1:0];
            end
        endcase
    end

    assign prod = r_r_sum * r_r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_vld <= 1'b0;
            r_m_vld <= 1'b0;
        end else if (adv) begin
            r_r_vld <= r_t_vld;
            r_m_vld <= r_r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_r_sse <= sse_round;
            r_r_sum <= sum_round;
            r_m_sse <= r_r_sse;
            r_m_sum <= r_r_sum;
            r_m_sq  <= prod[SSQ_W-1:0];
        end
    end

    assign shift = {1'b0, i_cfg.log2_wid} + {1'b0, i_cfg.log2_hgt};
    assign ssq   = r_m_sq >> shift;

    // In 8-bit mode the variance wraps; otherwise it is clamped at zero.
    always_comb begin
        case (i_cfg.mode)
            MODE_8BIT: var_val = r_m_sse - ssq[VAR_W-1:0];
            default: begin
                if (ssq <= {{(SSQ_W - SSE_OUT_W){1'b0}}, r_m_sse}) begin
                    var_val = r_m_sse - ssq[VAR_W-1:0];
                end else begin
                    var_val = '0;
                end
            end
        endcase
    end

    assign o_result.sse     = r_m_sse;
    assign o_result.sum     = r_m_sum;
    assign o_result.var_val = var_val;

    a_last_starts_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mid_pop && i_item.last) |=> r_t_vld)
        else $error("last pair did not start the finish pipeline");

    a_last_clears_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mid_pop && i_item.last) |=> (r_sse_acc == '0 && r_sum_acc == '0))
        else $error("accumulators not cleared after the last pair");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!adv) |=> ($stable(r_m_vld) && $stable(r_m_sse) && $stable(r_m_sq)))
        else $error("finish pipeline moved while stalled");

    a_clamp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_vld && i_cfg.mode != MODE_8BIT) |-> (var_val <= r_m_sse))
        else $error("clamped variance exceeds sse");

endmodule

@@ design/highbd_block_variance.sv @@
// Throughput: one sample pair per cycle while the back end is not stalled; a result per block,
// even for one-pair blocks. A result reaches the result ports once its last pair has passed
// the input register, the middle queue, the accumulator, two finish stages and the output queue.
// A full output queue stalls the back end; the middle queue and input register then fill.
// Reset is synchronous, active low: queues empty, accumulators zero, registers at defaults.
// ----------------------------------------------------------------------------
// highbd_block_variance: high bit-depth block variance and sse engine
// Front end stages sample pairs, a short queue decouples it from the back end,
// which accumulates and finishes each block into the output queue.
// ----------------------------------------------------------------------------
module highbd_block_variance
    import hbv_pkg::*;
#(
    parameter int MID_DEPTH = MID_Q_DEPTH,
    parameter int OUT_DEPTH = OUT_Q_DEPTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [SAMPLE_W-1:0]     i_src_sample,
    input  logic [SAMPLE_W-1:0]     i_ref_sample,
    input  logic                    i_last_sample,
    output logic                    empty,
    input  logic                    pop,
    output logic [SSE_OUT_W-1:0]    o_sse_out,
    output logic signed [SUM_W-1:0] o_sum_out,
    output logic [VAR_W-1:0]        o_variance_out,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_AW-1:0]       paddr,
    input  logic [APB_DW-1:0]       pwdata,
    output logic [APB_DW-1:0]       prdata,
    output logic                    pready
);

    t_cfg    cfg;
    t_item   front_item;
    t_item   mid_item;
    t_result back_result;
    t_result out_result;
    logic    mid_push, mid_pop, mid_full, mid_empty;
    logic    out_push, out_full;
    logic [$bits(t_item)-1:0]   mid_rdata;
    logic [$bits(t_result)-1:0] out_rdata;

    hbv_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    hbv_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_src_sample  (i_src_sample),
        .i_ref_sample  (i_ref_sample),
        .i_last_sample (i_last_sample),
        .i_q_full      (mid_full),
        .o_q_push      (mid_push),
        .o_item        (front_item)
    );

    hbv_fifo #(
        .WIDTH ($bits(t_item)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_wdata (front_item),
        .i_pop   (mid_pop),
        .o_rdata (mid_rdata),
        .o_full  (mid_full),
        .o_empty (mid_empty)
    );

    assign mid_item = t_item'(mid_rdata);

    hbv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_mid_empty (mid_empty),
        .i_item      (mid_item),
        .o_mid_pop   (mid_pop),
        .i_out_full  (out_full),
        .o_out_push  (out_push),
        .o_result    (back_result)
    );

    hbv_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_wdata (back_result),
        .i_pop   (pop && !empty),
        .o_rdata (out_rdata),
        .o_full  (out_full),
        .o_empty (empty)
    );

    assign out_result     = t_result'(out_rdata);
    assign o_sse_out      = out_result.sse;
    assign o_sum_out      = out_result.sum;
    assign o_variance_out = out_result.var_val;

endmodule

@@ test/highbd_block_variance_test.sv @@
// ----------------------------------------------------------------------------
// highbd_block_variance_test: self-checking bench for the block variance engine
// Sample pairs stream in from a queue through a driver with random idle bursts.
// Each block result popped from the output side is compared with a local
// prediction of sse, sum and variance for the bit-depth mode and block size.
// ----------------------------------------------------------------------------
module highbd_block_variance_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hbv_pkg::*;

    localparam int SAMPLE_MAX    = (1 << SAMPLE_W) - 1;
    localparam int DUT_LATENCY   = 5;
    localparam int SETTLE_CYCLES = 2 * DUT_LATENCY;
    localparam int HOLD_CYCLES   = 250;
    localparam int HOLD_AFTER    = 60;
    localparam int PHASE_PAIRS   = 150;

    // The register accepts 3 although the mode enum stops at 12-bit.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int STYLE_UNIFORM  = 0;
    localparam int STYLE_SRC_HIGH = 1;
    localparam int STYLE_REF_HIGH = 2;
    localparam int STYLE_CLOSE    = 3;
    localparam int STYLE_PEAK     = 4;

    typedef struct packed {
        logic [SAMPLE_W-1:0] src_smp;
        logic [SAMPLE_W-1:0] ref_smp;
        logic                last_smp;
    } t_pair;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    push = 1'b0;
    logic                    full;
    logic [SAMPLE_W-1:0]     i_src_sample = '0;
    logic [SAMPLE_W-1:0]     i_ref_sample = '0;
    logic                    i_last_sample = 1'b0;
    logic                    empty;
    logic                    pop = 1'b0;
    logic [SSE_OUT_W-1:0]    o_sse_out;
    logic signed [SUM_W-1:0] o_sum_out;
    logic [VAR_W-1:0]        o_variance_out;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [APB_AW-1:0]       paddr = '0;
    logic [APB_DW-1:0]       pwdata = '0;
    logic [APB_DW-1:0]       prdata;
    logic                    pready;

    // Shadow of the configuration registers and of the accumulators.
    logic [1:0]              mode_cfg = MODE_8BIT;
    logic [LOG2_W-1:0]       wid_cfg = 3'd4;
    logic [LOG2_W-1:0]       hgt_cfg = 3'd4;
    logic [SSE_ACC_W-1:0]    sse_acc = '0;
    logic signed [SUM_W-1:0] sum_acc = '0;

    t_pair   pair_queue[$];
    t_result variance_due[$];
    t_pair   next_pair;
    t_result due;
    int      pairs_taken = 0;
    int      mismatches = 0;
    int      send_gap = 0;
    int      take_gap = 0;
    logic    quiet = 1'b0;
    logic    hold_off = 1'b0;

    highbd_block_variance u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_src_sample   (i_src_sample),
        .i_ref_sample   (i_ref_sample),
        .i_last_sample  (i_last_sample),
        .empty          (empty),
        .pop            (pop),
        .o_sse_out      (o_sse_out),
        .o_sum_out      (o_sum_out),
        .o_variance_out (o_variance_out),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Accumulate one pair; on the closing pair round for the mode and queue the result.
    function automatic void account_pair(logic [SAMPLE_W-1:0] s, logic [SAMPLE_W-1:0] r,
                                         logic last);
        longint  diff, sum, sse, ssq, var_l;
        int      shift, sum_rnd, sse_rnd;
        t_result res;
        diff = longint'(s) - longint'(r);
        sse_acc = sse_acc + SSE_ACC_W'(diff * diff);
        sum_acc = sum_acc + SUM_W'(diff);
        if (!last) return;
        sum = sum_acc;
        sse = longint'(sse_acc);
        shift = int'(wid_cfg) + int'(hgt_cfg);
        if (mode_cfg == MODE_8BIT) begin
            sse = sse & 64'hFFFF_FFFF;
            ssq = (sum * sum) >> shift;
            var_l = (sse - ssq) & 64'hFFFF_FFFF;
        end else begin
            sum_rnd = (mode_cfg == MODE_10BIT) ? 2 : 4;
            sse_rnd = (mode_cfg == MODE_10BIT) ? 4 : 8;
            // Add half, then shift arithmetically: negative sums round toward minus infinity.
            sum = (sum + (64'sd1 <<< (sum_rnd - 1))) >>> sum_rnd;
            sse = ((sse + (64'sd1 <<< (sse_rnd - 1))) >>> sse_rnd) & 64'hFFFF_FFFF;
            ssq = (sum * sum) >> shift;
            var_l = (sse >= ssq) ? sse - ssq : 0;
        end
        res.sse = sse[SSE_OUT_W-1:0];
        res.sum = sum[SUM_W-1:0];
        res.var_val = var_l[VAR_W-1:0];
        variance_due.push_back(res);
        sse_acc = '0;
        sum_acc = '0;
    endfunction

    function automatic void queue_pair(logic [SAMPLE_W-1:0] s, logic [SAMPLE_W-1:0] r,
                                       logic last);
        t_pair p;
        p.src_smp = s;
        p.ref_smp = r;
        p.last_smp = last;
        pair_queue.push_back(p);
    endfunction

    task automatic queue_block(int n, int style, logic close);
        logic [SAMPLE_W-1:0] s, r;
        int                  t;
        for (int k = 0; k < n; k++) begin
            case (style)
                STYLE_SRC_HIGH: begin
                    s = SAMPLE_W'($urandom_range(SAMPLE_MAX - 255, SAMPLE_MAX));
                    r = SAMPLE_W'($urandom_range(0, 255));
                end
                STYLE_REF_HIGH: begin
                    s = SAMPLE_W'($urandom_range(0, 255));
                    r = SAMPLE_W'($urandom_range(SAMPLE_MAX - 255, SAMPLE_MAX));
                end
                STYLE_CLOSE: begin
                    s = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
                    t = int'(s) + int'($urandom_range(0, 8)) - 4;
                    r = (t < 0) ? '0 : (t > SAMPLE_MAX) ? '1 : SAMPLE_W'(t);
                end
                STYLE_PEAK: begin
                    s = '1;
                    r = '0;
                end
                default: begin
                    s = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
                    r = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
                end
            endcase
            queue_pair(s, r, close && (k == n - 1));
        end
    endtask

    task automatic write_reg(t_reg_idx idx, logic [APB_DW-1:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (pready) break;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MODE:     mode_cfg = val[1:0];
            REG_LOG2_WID: wid_cfg = val[LOG2_W-1:0];
            REG_LOG2_HGT: hgt_cfg = val[LOG2_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(logic [1:0] mode, logic [LOG2_W-1:0] w, logic [LOG2_W-1:0] h);
        write_reg(REG_MODE, APB_DW'(mode));
        write_reg(REG_LOG2_WID, APB_DW'(w));
        write_reg(REG_LOG2_HGT, APB_DW'(h));
    endtask

    // Wait for every queued pair to be taken and every result to come back, then let
    // trailing pairs of an unfinished block reach the accumulator.
    task automatic drain();
        while (pair_queue.size() != 0 || push || variance_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                account_pair(i_src_sample, i_ref_sample, i_last_sample);
                pairs_taken++;
            end
            if (!push || !full) begin
                if (send_gap > 0) begin
                    send_gap--;
                    push <= 1'b0;
                end else if (!quiet && $urandom_range(0, 15) == 0) begin
                    send_gap = $urandom_range(0, 10);
                    push <= 1'b0;
                end else if (pair_queue.size() > 0) begin
                    next_pair = pair_queue.pop_front();
                    push <= 1'b1;
                    i_src_sample <= next_pair.src_smp;
                    i_ref_sample <= next_pair.ref_smp;
                    i_last_sample <= next_pair.last_smp;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (variance_due.size() == 0) begin
                    $display("%0t: unexpected result beat: sse %0d sum %0d variance %0d",
                             $time, o_sse_out, o_sum_out, o_variance_out);
                    mismatches++;
                end else begin
                    due = variance_due.pop_front();
                    if (o_sse_out !== due.sse || o_sum_out !== due.sum ||
                        o_variance_out !== due.var_val) begin
                        $display({"%0t: result mismatch: sse exp %0d got %0d, ",
                                  "sum exp %0d got %0d, %s"},
                                 $time, due.sse, o_sse_out, due.sum, o_sum_out,
                                 $sformatf("variance exp %0d got %0d", due.var_val,
                                           o_variance_out));
                        mismatches++;
                    end
                end
            end
            if (hold_off) begin
                pop <= 1'b0;
            end else if (take_gap > 0) begin
                take_gap--;
                pop <= 1'b0;
            end else if (!quiet && $urandom_range(0, 15) == 0) begin
                take_gap = $urandom_range(0, 10);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // A long hold-off on the result side while one-pair blocks keep arriving,
    // so that the output and middle queues fill and full goes high.
    initial begin
        wait (pairs_taken >= HOLD_AFTER);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        #5_000_000;
        $display("[highbd_block_variance] ERROR");
        $finish;
    end

    initial begin
        int w_r, h_r, n, quota;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset configuration: 8-bit, 16x16. Largest positive and negative differences.
        queue_pair('1, '0, 1'b1);
        queue_pair('0, '1, 1'b1);
        queue_pair(12'hAAA, 12'h555, 1'b0);
        queue_pair(12'h555, 12'hAAA, 1'b0);
        queue_pair('1, '1, 1'b1);
        drain();

        // Zero size shift: the 8-bit variance goes negative and wraps.
        set_geometry(MODE_8BIT, 3'd0, 3'd0);
        queue_pair(12'd5, 12'd4, 1'b0);
        queue_pair(12'd5, 12'd4, 1'b1);
        drain();

        // 10-bit: the same block clamps at zero; a negative sum rounds down.
        set_geometry(MODE_10BIT, 3'd0, 3'd0);
        queue_pair(12'd7, 12'd6, 1'b0);
        queue_pair(12'd7, 12'd6, 1'b1);
        queue_pair(12'd0, 12'd3, 1'b1);
        queue_pair('1, '0, 1'b1);
        drain();

        // The unused mode code rounds like 12-bit; largest size fields.
        set_geometry(MODE_UNUSED, 3'd7, 3'd7);
        queue_pair('1, '0, 1'b1);
        queue_pair('0, '1, 1'b1);
        queue_pair(12'd100, 12'd99, 1'b1);
        drain();

        set_geometry(MODE_12BIT, 3'd6, 3'd6);
        queue_pair('0, '0, 1'b1);
        queue_pair('1, '1, 1'b0);
        queue_pair(12'd1, 12'd0, 1'b1);
        drain();

        // Random phases; the first one uses one-pair blocks to load the output side.
        for (int p = 0; p < 8; p++) begin
            w_r = (p == 0) ? 0 : $urandom_range(0, 4);
            h_r = (p == 0) ? 0 : $urandom_range(0, 6 - w_r);
            if (p == 7) begin
                w_r = 6;
                h_r = 1;
            end
            set_geometry(2'($urandom_range(MODE_8BIT, MODE_UNUSED)), LOG2_W'(w_r),
                         LOG2_W'(h_r));
            quota = 0;
            while (quota < PHASE_PAIRS) begin
                n = 1 << (w_r + h_r);
                if ($urandom_range(0, 7) == 0) n = $urandom_range(1, n + 3);
                queue_block(n, $urandom_range(STYLE_UNIFORM, STYLE_CLOSE), 1'b1);
                quota += n;
            end
            // Sometimes leave a block open so that it carries into the next setting.
            if ($urandom_range(0, 2) == 0) begin
                queue_block($urandom_range(1, 3), $urandom_range(STYLE_UNIFORM, STYLE_CLOSE),
                            1'b0);
            end
            drain();
        end

        // Final stretch without idling. Full-scale blocks in the 64x64 geometry,
        // then back-to-back small blocks.
        quiet <= 1'b1;
        set_geometry(MODE_10BIT, 3'd6, 3'd6);
        queue_block(64, STYLE_PEAK, 1'b1);
        drain();
        set_geometry(MODE_8BIT, 3'd6, 3'd6);
        queue_block(64, STYLE_PEAK, 1'b1);
        drain();
        set_geometry(MODE_12BIT, 3'd2, 3'd2);
        for (int k = 0; k < 8; k++) begin
            queue_block(16, $urandom_range(STYLE_UNIFORM, STYLE_CLOSE), 1'b1);
        end
        drain();

        if (mismatches == 0) begin
            $display("[highbd_block_variance] OK");
        end else begin
            $display("[highbd_block_variance] ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/hbv_pkg.sv
design/hbv_fifo.sv
design/hbv_regs.sv
design/hbv_front.sv
design/hbv_back.sv
design/highbd_block_variance.sv
test/highbd_block_variance_test.sv
